// ===== src/stt_pkg.sv =====
package stt_pkg;

	localparam int TOKEN_BUFFER = 1024;
	localparam int TLEN_W = $clog2(TOKEN_BUFFER);
	localparam logic [TLEN_W-1:0] TLEN_LIMIT = TLEN_W'(TOKEN_BUFFER - 1);
	localparam int LINE_W = 32;

	localparam logic REG_IGNORE_COLONS      = 1'b0;
	localparam logic REG_KEEP_LINE_COMMENTS = 1'b1;

	typedef enum logic [1:0] {
		KIND_WORD  = 2'd0,
		KIND_QUOTE = 2'd1,
		KIND_PUNCT = 2'd2,
		KIND_EOI   = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0]        tok_char;
		logic              has_char;
		kind_t             tok_kind;
		logic              tok_start;
		logic              tok_end;
		logic [LINE_W-1:0] line_count;
		logic              last_of_step;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t    r1;
		result_t    r0;
	} step_t;

	typedef struct packed {
		logic ignore_colons;
		logic keep_line_comments;
	} cfg_t;

endpackage

// ===== src/stt_ifs.sv =====
interface stt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source(output valid, output in_byte, input ready);
	modport sink(input valid, input in_byte, output ready);
endinterface

interface stt_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  tok_char;
	logic        has_char;
	logic [1:0]  tok_kind;
	logic        tok_start;
	logic        tok_end;
	logic [31:0] line_count;
	logic        last_of_step;

	modport source(output valid, output tok_char, output has_char, output tok_kind,
		output tok_start, output tok_end, output line_count, output last_of_step,
		input ready);
	modport sink(input valid, input tok_char, input has_char, input tok_kind,
		input tok_start, input tok_end, input line_count, input last_of_step,
		output ready);
endinterface

// ===== src/stt_scan.sv =====
module stt_scan (
	input  logic               clk,
	input  logic               arst_n,
	input  stt_pkg::cfg_t      cfg,
	stt_in_if.sink             text,
	output stt_pkg::step_t     step,
	output logic               step_valid,
	input  logic               step_ready
);

	typedef enum logic [4:0] {
		MODE_IDLE  = 5'b00001,
		MODE_WORD  = 5'b00010,
		MODE_QUOTE = 5'b00100,
		MODE_LINE  = 5'b01000,
		MODE_BLOCK = 5'b10000
	} mode_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_APOS   = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	function automatic logic is_space(input logic [7:0] b);
		return (b <= CH_SPACE) || b[7];
	endfunction

	function automatic logic is_punct(input logic [7:0] b, input logic ign_colon);
		logic r;
		case (b)
			CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK,
			CH_APOS, CH_SLASH, CH_COMMA, CH_SEMI: r = 1'b1;
			CH_COLON: r = !ign_colon;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic stt_pkg::result_t mk(input logic [7:0] ch, input logic has,
		input stt_pkg::kind_t kind, input logic s, input logic e);
		stt_pkg::result_t r;
		r = '0;
		r.tok_char  = ch;
		r.has_char  = has;
		r.tok_kind  = kind;
		r.tok_start = s;
		r.tok_end   = e;
		return r;
	endfunction

	logic                        valid_s1;
	logic [7:0]                  byte_s1;
	mode_t                       mode_q, mode_d;
	logic                        slash_q, slash_d;
	logic                        star_q, star_d;
	logic [stt_pkg::TLEN_W-1:0]  tlen_q, tlen_d;
	logic [stt_pkg::LINE_W-1:0]  nl_q, nl_d;
	stt_pkg::result_t            res [2];
	logic [1:0]                  n;
	logic                        as_idle;
	logic                        advance;
	logic                        b_space, b_punct;

	assign b_space = is_space(byte_s1);
	assign b_punct = is_punct(byte_s1, cfg.ignore_colons);

	always_comb begin
		mode_d  = mode_q;
		slash_d = slash_q;
		star_d  = star_q;
		tlen_d  = tlen_q;
		nl_d    = nl_q;
		res[0]  = '0;
		res[1]  = '0;
		n       = 2'd0;
		as_idle = 1'b0;
		case (mode_q)
			MODE_WORD: begin
				if (b_space || b_punct) begin
					res[0]  = mk(CH_NUL, 1'b0, stt_pkg::KIND_WORD, 1'b0, 1'b1);
					n       = 2'd1;
					tlen_d  = '0;
					as_idle = 1'b1;
				end else if (tlen_q < stt_pkg::TLEN_LIMIT) begin
					res[0] = mk(byte_s1, 1'b1, stt_pkg::KIND_WORD, 1'b0, 1'b0);
					n      = 2'd1;
					tlen_d = tlen_q + stt_pkg::TLEN_W'(1);
				end
			end
			MODE_QUOTE: begin
				if (byte_s1 == CH_DQUOTE || byte_s1 == CH_NUL || byte_s1 == CH_NL ||
					tlen_q >= stt_pkg::TLEN_LIMIT) begin
					res[0] = mk(CH_NUL, 1'b0, stt_pkg::KIND_QUOTE, tlen_q == '0, 1'b1);
					n      = 2'd1;
					mode_d = MODE_IDLE;
					tlen_d = '0;
					if (byte_s1 == CH_NUL) begin
						res[1]  = mk(CH_NUL, 1'b0, stt_pkg::KIND_EOI, 1'b1, 1'b1);
						n       = 2'd2;
						star_d  = 1'b0;
						slash_d = 1'b0;
					end
				end else begin
					res[0] = mk(byte_s1, 1'b1, stt_pkg::KIND_QUOTE, tlen_q == '0, 1'b0);
					n      = 2'd1;
					tlen_d = tlen_q + stt_pkg::TLEN_W'(1);
				end
			end
			MODE_LINE: begin
				if (byte_s1 == CH_NUL) begin
					res[0]  = mk(CH_NUL, 1'b0, stt_pkg::KIND_EOI, 1'b1, 1'b1);
					n       = 2'd1;
					mode_d  = MODE_IDLE;
					star_d  = 1'b0;
					slash_d = 1'b0;
					tlen_d  = '0;
				end else if (byte_s1 == CH_NL) begin
					nl_d   = nl_q + 32'd1;
					mode_d = MODE_IDLE;
				end
			end
			MODE_BLOCK: begin
				if (byte_s1 == CH_NUL) begin
					res[0]  = mk(CH_NUL, 1'b0, stt_pkg::KIND_EOI, 1'b1, 1'b1);
					n       = 2'd1;
					mode_d  = MODE_IDLE;
					star_d  = 1'b0;
					slash_d = 1'b0;
					tlen_d  = '0;
				end else if (star_q && byte_s1 == CH_SLASH) begin
					star_d = 1'b0;
					mode_d = MODE_IDLE;
				end else begin
					if (byte_s1 == CH_NL) begin
						nl_d = nl_q + 32'd1;
					end
					star_d = (byte_s1 == CH_STAR);
				end
			end
			default: begin
				if (slash_q) begin
					slash_d = 1'b0;
					if (byte_s1 == CH_SLASH && !cfg.keep_line_comments) begin
						mode_d = MODE_LINE;
					end else if (byte_s1 == CH_STAR) begin
						mode_d = MODE_BLOCK;
						star_d = 1'b1;
					end else begin
						res[0]  = mk(CH_SLASH, 1'b1, stt_pkg::KIND_PUNCT, 1'b1, 1'b1);
						n       = 2'd1;
						as_idle = 1'b1;
					end
				end else begin
					as_idle = 1'b1;
				end
			end
		endcase

		// byte handled as between tokens
		if (as_idle) begin
			mode_d = MODE_IDLE;
			if (byte_s1 == CH_NUL) begin
				res[n[0]] = mk(CH_NUL, 1'b0, stt_pkg::KIND_EOI, 1'b1, 1'b1);
				n         = n + 2'd1;
				star_d    = 1'b0;
				slash_d   = 1'b0;
				tlen_d    = '0;
			end else if (b_space) begin
				if (byte_s1 == CH_NL) begin
					nl_d = nl_q + 32'd1;
				end
			end else if (byte_s1 == CH_SLASH) begin
				slash_d = 1'b1;
			end else if (byte_s1 == CH_DQUOTE) begin
				mode_d = MODE_QUOTE;
				tlen_d = '0;
			end else if (b_punct) begin
				res[n[0]] = mk(byte_s1, 1'b1, stt_pkg::KIND_PUNCT, 1'b1, 1'b1);
				n         = n + 2'd1;
			end else begin
				res[n[0]] = mk(byte_s1, 1'b1, stt_pkg::KIND_WORD, 1'b1, 1'b0);
				n         = n + 2'd1;
				mode_d    = MODE_WORD;
				tlen_d    = stt_pkg::TLEN_W'(1);
			end
		end

		res[0].line_count   = nl_d;
		res[1].line_count   = nl_d;
		res[0].last_of_step = (n == 2'd1);
		res[1].last_of_step = 1'b1;
	end

	assign step.cnt   = n;
	assign step.r0    = res[0];
	assign step.r1    = res[1];
	assign step_valid = valid_s1 && (n != 2'd0);
	assign advance    = valid_s1 && ((n == 2'd0) || step_ready);
	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= MODE_IDLE;
			slash_q  <= 1'b0;
			star_q   <= 1'b0;
			tlen_q   <= '0;
			nl_q     <= '0;
		end else begin
			if (text.ready) begin
				valid_s1 <= text.valid;
			end
			if (advance) begin
				mode_q  <= mode_d;
				slash_q <= slash_d;
				star_q  <= star_d;
				tlen_q  <= tlen_d;
				nl_q    <= nl_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.in_byte;
		end
	end

	a_word_len: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_WORD |-> tlen_q != '0)
		else $error("word open with zero length");

	a_slash_idle: assert property (@(posedge clk) disable iff (!arst_n)
		slash_q |-> mode_q == MODE_IDLE)
		else $error("pending slash outside idle");

endmodule

// ===== src/stt_outbuf.sv =====
module stt_outbuf (
	input  logic           clk,
	input  logic           arst_n,
	input  stt_pkg::step_t step,
	input  logic           step_valid,
	output logic           step_ready,
	stt_out_if.source      token
);

	stt_pkg::result_t slot0_q, slot1_q;
	logic [1:0]       cnt_q;
	logic             fire;
	logic             load;

	assign fire       = token.valid && token.ready;
	assign step_ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && token.ready);
	assign load       = step_valid && step_ready;

	assign token.valid        = cnt_q != 2'd0;
	assign token.tok_char     = slot0_q.tok_char;
	assign token.has_char     = slot0_q.has_char;
	assign token.tok_kind     = slot0_q.tok_kind;
	assign token.tok_start    = slot0_q.tok_start;
	assign token.tok_end      = slot0_q.tok_end;
	assign token.line_count   = slot0_q.line_count;
	assign token.last_of_step = slot0_q.last_of_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= step.cnt;
		end else if (fire) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= step.r0;
			slot1_q <= step.r1;
		end else if (fire) begin
			slot0_q <= slot1_q;
		end
	end

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !slot0_q.last_of_step && slot1_q.last_of_step)
		else $error("result pair out of order");

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && cnt_q == 2'd2) |=> token.valid && token.last_of_step)
		else $error("second result of a byte lost");

endmodule

// ===== src/source_text_tokenizer_core.sv =====
// Byte-serial tokenizer for C-like text. One text byte per beat on text (0 ends the input);
// one token character or marker per beat on token, with start/end marks, kind and the
// running newline count. A byte passes the input register and then the result register;
// the block accepts a byte every cycle while each byte yields at most one result and the
// token side is ready. A byte that closes a word or string and also yields punctuation or
// the end marker gives two results; the single-result output port then holds back the
// input until the second result is taken. Bytes that give no result (whitespace, comments)
// never wait on the output side. The user writes ignore_colons (index 0) and
// keep_line_comments (index 1) only while the block is idle; the block does not enforce it.
module source_text_tokenizer_core (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic      cfg_wdata,
	stt_in_if.sink    text,
	stt_out_if.source token
);

	stt_pkg::cfg_t  cfg_q;
	stt_pkg::step_t step;
	logic           step_valid;
	logic           step_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				stt_pkg::REG_IGNORE_COLONS:      cfg_q.ignore_colons      <= cfg_wdata;
				stt_pkg::REG_KEEP_LINE_COMMENTS: cfg_q.keep_line_comments <= cfg_wdata;
				default: ;
			endcase
		end
	end

	stt_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.text       (text),
		.step       (step),
		.step_valid (step_valid),
		.step_ready (step_ready)
	);

	stt_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.step_valid (step_valid),
		.step_ready (step_ready),
		.token      (token)
	);

endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_WORD,
		SCAN_QUOTE,
		SCAN_LINE,
		SCAN_BLOCK
	} scan_t;

	typedef struct {
		logic [7:0]       b;
		bit               typed;
		stt_pkg::result_t want;
	} row_t;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH = "/";
	localparam logic [7:0] CH_STAR  = "*";
	localparam logic [7:0] PUNCTS [10] = '{"{", "}", "(", ")", "[", "]", "'", ",", ";", ":"};

	localparam int GAP_PCT     = 14;
	localparam int PHASE_BYTES = 30;
	localparam int LONG_LEN    = stt_pkg::TOKEN_BUFFER + 2;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic cfg_wdata;

	stt_in_if  text_if();
	stt_out_if token_if();

	source_text_tokenizer_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.text      (text_if),
		.token     (token_if)
	);

	always #2 clk = ~clk;

	// tokenizer state as seen by the predictor
	scan_t       mode_q;
	bit          slash_q;
	bit          star_q;
	int unsigned len_q;
	logic [31:0] lines_q;
	bit          ign_colons;
	bit          keep_lines;

	stt_pkg::result_t step_res[$];
	stt_pkg::result_t pending_tokens[$];
	logic [7:0]       stim_q[$];
	row_t             dir_rows[25];

	int errors;
	int beats_checked;
	int bytes_sent;
	int active_bytes;
	int src_gap;
	int sink_gap;

	function automatic bit is_blank(logic [7:0] b);
		return b <= 8'd32 || b >= 8'd128;
	endfunction

	function automatic bit is_sep(logic [7:0] b);
		case (b)
			"{", "}", "(", ")", "[", "]", "'", "/", ",", ";": return 1'b1;
			":": return !ign_colons;
			default: return 1'b0;
		endcase
	endfunction

	function automatic stt_pkg::result_t make_res(logic [7:0] ch, logic has,
			stt_pkg::kind_t kind, logic s, logic e, logic [31:0] lines, logic last);
		stt_pkg::result_t r;
		r.tok_char     = ch;
		r.has_char     = has;
		r.tok_kind     = kind;
		r.tok_start    = s;
		r.tok_end      = e;
		r.line_count   = lines;
		r.last_of_step = last;
		return r;
	endfunction

	function automatic void emit(logic [7:0] ch, logic has, stt_pkg::kind_t kind, logic s,
			logic e);
		step_res.push_back(make_res(ch, has, kind, s, e, '0, 1'b0));
	endfunction

	function automatic void close_input();
		emit(8'd0, 1'b0, stt_pkg::KIND_EOI, 1'b1, 1'b1);
		mode_q  = SCAN_IDLE;
		star_q  = 1'b0;
		slash_q = 1'b0;
		len_q   = 0;
	endfunction

	function automatic void scan_idle(logic [7:0] b);
		mode_q = SCAN_IDLE;
		if (b == 8'd0) begin
			close_input();
		end else if (is_blank(b)) begin
			if (b == CH_NL)
				lines_q++;
		end else if (b == CH_SLASH) begin
			slash_q = 1'b1;
		end else if (b == CH_QUOTE) begin
			mode_q = SCAN_QUOTE;
			len_q  = 0;
		end else if (is_sep(b)) begin
			emit(b, 1'b1, stt_pkg::KIND_PUNCT, 1'b1, 1'b1);
		end else begin
			emit(b, 1'b1, stt_pkg::KIND_WORD, 1'b1, 1'b0);
			mode_q = SCAN_WORD;
			len_q  = 1;
		end
	endfunction

	function automatic int tokenize_byte(logic [7:0] b);
		int unsigned limit = stt_pkg::TOKEN_BUFFER - 1;
		step_res.delete();
		case (mode_q)
			SCAN_WORD: begin
				if (is_blank(b) || is_sep(b)) begin
					emit(8'd0, 1'b0, stt_pkg::KIND_WORD, 1'b0, 1'b1);
					len_q = 0;
					scan_idle(b);
				end else if (len_q < limit) begin
					emit(b, 1'b1, stt_pkg::KIND_WORD, 1'b0, 1'b0);
					len_q++;
				end
			end
			SCAN_QUOTE: begin
				if (b == CH_QUOTE || b == 8'd0 || b == CH_NL || len_q >= limit) begin
					emit(8'd0, 1'b0, stt_pkg::KIND_QUOTE, len_q == 0, 1'b1);
					mode_q = SCAN_IDLE;
					len_q  = 0;
					if (b == 8'd0)
						close_input();
				end else begin
					emit(b, 1'b1, stt_pkg::KIND_QUOTE, len_q == 0, 1'b0);
					len_q++;
				end
			end
			SCAN_LINE: begin
				if (b == 8'd0) begin
					close_input();
				end else if (b == CH_NL) begin
					lines_q++;
					mode_q = SCAN_IDLE;
				end
			end
			SCAN_BLOCK: begin
				if (b == 8'd0) begin
					close_input();
				end else if (star_q && b == CH_SLASH) begin
					star_q = 1'b0;
					mode_q = SCAN_IDLE;
				end else begin
					if (b == CH_NL)
						lines_q++;
					star_q = (b == CH_STAR);
				end
			end
			default: begin
				if (slash_q) begin
					slash_q = 1'b0;
					if (b == CH_SLASH && !keep_lines) begin
						mode_q = SCAN_LINE;
					end else if (b == CH_STAR) begin
						mode_q = SCAN_BLOCK;
						star_q = 1'b1;
					end else begin
						emit(CH_SLASH, 1'b1, stt_pkg::KIND_PUNCT, 1'b1, 1'b1);
						scan_idle(b);
					end
				end else begin
					scan_idle(b);
				end
			end
		endcase
		foreach (step_res[k]) begin
			step_res[k].line_count   = lines_q;
			step_res[k].last_of_step = (k == step_res.size() - 1);
		end
		return step_res.size();
	endfunction

	task automatic report_mismatch(string msg);
		errors++;
		if (errors <= 100)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	task automatic check_beat();
		stt_pkg::result_t want;
		string            msg;
		if (pending_tokens.size() == 0) begin
			report_mismatch($sformatf("token beat with nothing expected: char %02h kind %0d",
				token_if.tok_char, token_if.tok_kind));
		end else begin
			want = pending_tokens.pop_front();
			beats_checked++;
			msg = "";
			if (token_if.tok_char !== want.tok_char)
				msg = {msg, $sformatf(" tok_char %02h/%02h", token_if.tok_char, want.tok_char)};
			if (token_if.has_char !== want.has_char)
				msg = {msg, $sformatf(" has_char %b/%b", token_if.has_char, want.has_char)};
			if (token_if.tok_kind !== want.tok_kind)
				msg = {msg, $sformatf(" tok_kind %0d/%0d", token_if.tok_kind, want.tok_kind)};
			if (token_if.tok_start !== want.tok_start)
				msg = {msg, $sformatf(" tok_start %b/%b", token_if.tok_start, want.tok_start)};
			if (token_if.tok_end !== want.tok_end)
				msg = {msg, $sformatf(" tok_end %b/%b", token_if.tok_end, want.tok_end)};
			if (token_if.line_count !== want.line_count)
				msg = {msg, $sformatf(" line_count %0d/%0d", token_if.line_count,
					want.line_count)};
			if (token_if.last_of_step !== want.last_of_step)
				msg = {msg, $sformatf(" last_of_step %b/%b", token_if.last_of_step,
					want.last_of_step)};
			if (msg != "")
				report_mismatch($sformatf("token beat %0d (got/want):%s", beats_checked, msg));
		end
	endtask

	always @(posedge clk) begin
		if (token_if.valid && token_if.ready)
			check_beat();
	end

	always @(posedge clk)
		token_if.ready <= ($urandom_range(99) >= sink_gap);

	task automatic send_byte(logic [7:0] b, bit typed = 1'b0, stt_pkg::result_t want = '0);
		scan_t       m;
		logic [31:0] l;
		bit          s;
		int          n;
		while (src_gap != 0 && $urandom_range(99) < src_gap) begin
			text_if.valid <= 1'b0;
			@(posedge clk);
		end
		text_if.valid   <= 1'b1;
		text_if.in_byte <= b;
		do @(posedge clk); while (!text_if.ready);
		m = mode_q;
		l = lines_q;
		s = slash_q;
		n = tokenize_byte(b);
		if (typed)
			pending_tokens.push_back(want);
		else
			foreach (step_res[k]) pending_tokens.push_back(step_res[k]);
		bytes_sent++;
		if (n != 0 || m != mode_q || l != lines_q || s != slash_q)
			active_bytes++;
	endtask

	task automatic drain_tokens();
		text_if.valid <= 1'b0;
		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_config(logic ign, logic keep);
		cfg_we    <= 1'b1;
		cfg_index <= stt_pkg::REG_IGNORE_COLONS;
		cfg_wdata <= ign;
		@(posedge clk);
		cfg_index <= stt_pkg::REG_KEEP_LINE_COMMENTS;
		cfg_wdata <= keep;
		@(posedge clk);
		cfg_we     <= 1'b0;
		ign_colons = ign;
		keep_lines = keep;
	endtask

	function automatic logic [7:0] word_byte();
		logic [7:0] b;
		if ($urandom_range(99) < 60)
			b = 8'($urandom_range(97, 122));
		else
			do b = 8'($urandom_range(33, 126)); while (b == CH_QUOTE || (is_sep(b) && b != ":"));
		return b;
	endfunction

	function automatic logic [7:0] blank_byte();
		case ($urandom_range(4))
			0: return " ";
			1: return 8'h09;
			2: return CH_NL;
			3: return 8'($urandom_range(1, 32));
			default: return 8'($urandom_range(128, 255));
		endcase
	endfunction

	function automatic void add_fragment();
		int         pick = $urandom_range(99);
		int         len = $urandom_range(8);
		logic [7:0] b;
		if (pick < 25) begin
			repeat (len + 1) stim_q.push_back(word_byte());
		end else if (pick < 40) begin
			repeat ($urandom_range(1, 3)) stim_q.push_back(blank_byte());
		end else if (pick < 55) begin
			stim_q.push_back(PUNCTS[$urandom_range(9)]);
		end else if (pick < 66) begin
			stim_q.push_back(CH_QUOTE);
			repeat (len) begin
				do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_NL);
				stim_q.push_back(b);
			end
			stim_q.push_back($urandom_range(9) == 0 ? CH_NL : CH_QUOTE);
		end else if (pick < 73) begin
			stim_q.push_back(CH_SLASH);
			stim_q.push_back(CH_SLASH);
			repeat (len) begin
				do b = 8'($urandom_range(1, 255)); while (b == CH_NL);
				stim_q.push_back(b);
			end
			stim_q.push_back(CH_NL);
		end else if (pick < 83) begin
			stim_q.push_back(CH_SLASH);
			stim_q.push_back(CH_STAR);
			if ($urandom_range(3) == 0) begin
				stim_q.push_back(CH_SLASH);
			end else begin
				repeat (len) begin
					case ($urandom_range(3))
						0: b = CH_STAR;
						1: b = CH_NL;
						2: b = CH_SLASH;
						default: b = 8'($urandom_range(1, 255));
					endcase
					stim_q.push_back(b);
				end
				stim_q.push_back(CH_STAR);
				stim_q.push_back(CH_SLASH);
			end
		end else if (pick < 87) begin
			stim_q.push_back(CH_SLASH);
		end else if (pick < 91) begin
			stim_q.push_back(8'd0);
		end else begin
			repeat ($urandom_range(1, 3)) stim_q.push_back(8'($urandom_range(255)));
		end
	endfunction

	task automatic run_phase(int target, bit mid_drain);
		int start = bytes_sent;
		bit drained = 1'b0;
		while (bytes_sent - start < target) begin
			if (stim_q.size() == 0)
				add_fragment();
			send_byte(stim_q.pop_front());
			if (mid_drain && !drained && bytes_sent - start >= target / 2) begin
				drain_tokens();
				drained = 1'b1;
			end
		end
		while (stim_q.size() != 0) send_byte(stim_q.pop_front());
		drain_tokens();
	endtask

	// a string or a word past the buffer size
	task automatic send_long_token();
		if ($urandom_range(1) == 0) begin
			send_byte(CH_QUOTE);
			repeat (LONG_LEN) send_byte(8'($urandom_range(65, 90)));
			send_byte(CH_QUOTE);
			send_byte(CH_NL);
		end else begin
			repeat (LONG_LEN) send_byte(8'($urandom_range(97, 122)));
		end
		send_byte(8'd0);
	endtask

	initial begin
		cfg_we          = 1'b0;
		cfg_index       = stt_pkg::REG_IGNORE_COLONS;
		cfg_wdata       = 1'b0;
		text_if.valid   = 1'b0;
		text_if.in_byte = 8'd0;
		token_if.ready  = 1'b0;
		arst_n          = 1'b0;
		src_gap         = GAP_PCT;
		sink_gap        = GAP_PCT;
		mode_q          = SCAN_IDLE;
		len_q           = 0;
		lines_q         = '0;

		dir_rows = '{
			'{"{", 1'b1, make_res("{", 1'b1, stt_pkg::KIND_PUNCT, 1'b1, 1'b1, 32'd0, 1'b1)},
			'{8'h00, 1'b1, make_res(8'h00, 1'b0, stt_pkg::KIND_EOI, 1'b1, 1'b1, 32'd0, 1'b1)},
			'{8'hFF,    1'b0, '0},
			'{CH_NL,    1'b0, '0},
			'{"a",      1'b0, '0},
			'{8'h7F,    1'b0, '0},
			'{":",      1'b0, '0},
			'{CH_QUOTE, 1'b0, '0},
			'{CH_QUOTE, 1'b1,
				make_res(8'h00, 1'b0, stt_pkg::KIND_QUOTE, 1'b1, 1'b1, 32'd1, 1'b1)},
			'{CH_QUOTE, 1'b0, '0},
			'{"x",      1'b0, '0},
			'{CH_NL,    1'b0, '0},
			'{CH_SLASH, 1'b0, '0},
			'{CH_STAR,  1'b0, '0},
			'{CH_SLASH, 1'b0, '0},
			'{CH_SLASH, 1'b0, '0},
			'{CH_SLASH, 1'b0, '0},
			'{CH_NL,    1'b0, '0},
			'{CH_SLASH, 1'b0, '0},
			'{"b",      1'b0, '0},
			'{8'h00,    1'b0, '0},
			'{CH_SLASH, 1'b0, '0},
			'{CH_STAR,  1'b0, '0},
			'{8'h00, 1'b1, make_res(8'h00, 1'b0, stt_pkg::KIND_EOI, 1'b1, 1'b1, 32'd2, 1'b1)},
			'{8'h01,    1'b0, '0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_config(1'b0, 1'b0);

		foreach (dir_rows[i])
			send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);
		drain_tokens();

		set_config(1'b1, 1'b0);
		run_phase(PHASE_BYTES, 1'b1);

		// back-to-back stretch
		src_gap  = 0;
		sink_gap = 0;
		set_config(1'b0, 1'b1);
		run_phase(PHASE_BYTES, 1'b0);

		src_gap  = GAP_PCT;
		sink_gap = GAP_PCT;
		set_config(1'b1, 1'b1);
		run_phase(PHASE_BYTES, 1'b0);

		set_config(1'b0, 1'b0);
		send_long_token();
		drain_tokens();
		run_phase(PHASE_BYTES, 1'b0);

		set_config(1'($urandom_range(1)), 1'($urandom_range(1)));
		run_phase(PHASE_BYTES, 1'b0);

		repeat (10) @(posedge clk);
		$display("tokenizer run: %0d text bytes (%0d with effect), %0d token beats checked",
			bytes_sent, active_bytes, beats_checked);
		$display("colon and line-comment settings all visited, %0d newlines, long token cut",
			lines_q);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#3ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
src/stt_pkg.sv
src/stt_ifs.sv
src/stt_scan.sv
src/stt_outbuf.sv
src/source_text_tokenizer_core.sv
tb/tb.sv
